### src/rne_pkg.sv
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types, constants and helper functions for the Roman numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

   localparam int unsigned ValueW  = 14;
   localparam int unsigned LetterW = 7;
   localparam int unsigned SymW    = 3;
   localparam int unsigned MaxSyms = 15;
   localparam int unsigned SeqW    = SymW * MaxSyms;
   localparam int unsigned LenW    = 4;
   localparam int unsigned PatW    = SymW * 4;

   // reciprocal constants for the digit split
   localparam logic [14:0] Recip1000 = 15'd16778;  // value / 1000 = (value * k) >> 24
   localparam logic [10:0] Recip100  = 11'd1311;   // r / 100 = (r * k) >> 17
   localparam logic [7:0]  Recip10   = 8'd205;     // r / 10 = (r * k) >> 11
   localparam logic [9:0]  Thousand  = 10'd1000;
   localparam logic [6:0]  Hundred   = 7'd100;
   localparam logic [3:0]  Ten       = 4'd10;

   typedef enum logic [SymW-1:0] {
      SYM_NONE,
      SYM_I,
      SYM_V,
      SYM_X,
      SYM_L,
      SYM_C,
      SYM_D,
      SYM_M
   } sym_type;

   typedef struct packed {
      logic [1:0] m_cnt;
      logic [3:0] hun;
      logic [3:0] ten;
      logic [3:0] one;
   } digits_type;

   function automatic logic [LetterW-1:0] sym_ascii(input sym_type s);
      logic [LetterW-1:0] a;
      unique case (s)
         SYM_I:   a = 7'h49;
         SYM_V:   a = 7'h56;
         SYM_X:   a = 7'h58;
         SYM_L:   a = 7'h4C;
         SYM_C:   a = 7'h43;
         SYM_D:   a = 7'h44;
         SYM_M:   a = 7'h4D;
         default: a = 7'h00;
      endcase
      return a;
   endfunction

   // first symbol in the low bits
   function automatic logic [PatW-1:0] digit_syms(input logic [3:0] d, input sym_type u,
                                                  input sym_type f, input sym_type t);
      logic [PatW-1:0] p;
      case (d)
         4'd1:    p = {SYM_NONE, SYM_NONE, SYM_NONE, u};
         4'd2:    p = {SYM_NONE, SYM_NONE, u, u};
         4'd3:    p = {SYM_NONE, u, u, u};
         4'd4:    p = {SYM_NONE, SYM_NONE, f, u};
         4'd5:    p = {SYM_NONE, SYM_NONE, SYM_NONE, f};
         4'd6:    p = {SYM_NONE, SYM_NONE, u, f};
         4'd7:    p = {SYM_NONE, u, u, f};
         4'd8:    p = {u, u, u, f};
         4'd9:    p = {SYM_NONE, SYM_NONE, t, u};
         default: p = '0;
      endcase
      return p;
   endfunction

   function automatic logic [2:0] digit_len(input logic [3:0] d);
      logic [2:0] n;
      case (d)
         4'd1, 4'd5:       n = 3'd1;
         4'd2, 4'd4, 4'd6,
         4'd9:             n = 3'd2;
         4'd3, 4'd7:       n = 3'd3;
         4'd8:             n = 3'd4;
         default:          n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [5:0] sym_shift(input logic [LenW-1:0] n);
      return 6'(n) * 6'd3;
   endfunction

endpackage

### src/roman_numeral_encoder_core.sv
// ----------------------------------------------------------------------------
// roman_numeral_encoder_core
// Converts a 14-bit value into its Roman numeral as a stream of ASCII letters.
// ----------------------------------------------------------------------------
// Each accepted value (thousands taken modulo ten, M only for 1 to 3) yields
// one to fifteen results, one letter per transfer, the final one marked by
// rsp_last; a value with no letters yields one result with rsp_empty_res set
// and letter 0. A new value can be taken every cycle until back-pressure from
// the busy letter emitter or the result side reaches the input: an item holds
// the emitter until its last letter (or its empty result) is loaded, and the
// next item can be taken as that last letter is loaded. The first letter passes
// the digit stages, the pack stages, the held sequence and the result register.
module roman_numeral_encoder_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [rne_pkg::ValueW-1:0]   req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rne_pkg::LetterW-1:0]  rsp_letter,
   output logic                         rsp_last,
   output logic                         rsp_empty_res
);
   import rne_pkg::*;

   logic            dig_valid, dig_ready;
   digits_type      dig_data;
   logic            pk_valid, pk_ready;
   logic [SeqW-1:0] pk_seq;
   logic [LenW-1:0] pk_len;

   rne_digits u_digits (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_value   (req_value),
      .out_valid  (dig_valid),
      .out_ready  (dig_ready),
      .out_digits (dig_data)
   );

   rne_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dig_valid),
      .in_ready  (dig_ready),
      .in_digits (dig_data),
      .out_valid (pk_valid),
      .out_ready (pk_ready),
      .out_seq   (pk_seq),
      .out_len   (pk_len)
   );

   rne_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (pk_valid),
      .in_ready      (pk_ready),
      .in_seq        (pk_seq),
      .in_len        (pk_len),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_letter    (rsp_letter),
      .rsp_last      (rsp_last),
      .rsp_empty_res (rsp_empty_res)
   );

endmodule

### src/rne_digits.sv
// ----------------------------------------------------------------------------
// rne_digits
// Six-stage pipeline splitting the value into thousands count and the
// hundreds, tens and units digits by reciprocal multiplication.
// ----------------------------------------------------------------------------
module rne_digits (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [rne_pkg::ValueW-1:0]  in_value,
   output logic                        out_valid,
   input  logic                        out_ready,
   output rne_pkg::digits_type         out_digits
);
   import rne_pkg::*;

   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s6_v_ff;
   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, s6_rdy;

   logic [ValueW-1:0] s1_val_ff, s1_val_in;
   logic [4:0]        s1_q_ff, s1_q_in;
   logic [28:0]       prod_1000;

   logic [9:0]        s2_r_ff, s2_r_in;
   logic [1:0]        s2_m_ff, s2_m_in;
   logic [4:0]        th_digit;
   logic [ValueW-1:0] q_times;

   logic [9:0]        s3_r_ff;
   logic [1:0]        s3_m_ff;
   logic [3:0]        s3_h_ff, s3_h_in;
   logic [20:0]       prod_100;

   logic [1:0]        s4_m_ff;
   logic [3:0]        s4_h_ff;
   logic [6:0]        s4_r_ff, s4_r_in;
   logic [9:0]        h_times;

   logic [1:0]        s5_m_ff;
   logic [3:0]        s5_h_ff;
   logic [6:0]        s5_r_ff;
   logic [3:0]        s5_t_ff, s5_t_in;
   logic [14:0]       prod_10;

   digits_type        s6_d_ff, s6_d_in;
   logic [6:0]        t_times;

   assign s6_rdy   = !s6_v_ff || out_ready;
   assign s5_rdy   = !s5_v_ff || s6_rdy;
   assign s4_rdy   = !s4_v_ff || s5_rdy;
   assign s3_rdy   = !s3_v_ff || s4_rdy;
   assign s2_rdy   = !s2_v_ff || s3_rdy;
   assign s1_rdy   = !s1_v_ff || s2_rdy;
   assign in_ready = s1_rdy;

   always_comb begin
      prod_1000 = 29'(in_value) * 29'(Recip1000);
      s1_val_in = in_value;
      s1_q_in   = prod_1000[28:24];

      q_times   = ValueW'(s1_q_ff) * ValueW'(Thousand);
      s2_r_in   = 10'(s1_val_ff - q_times);
      th_digit  = (s1_q_ff >= 5'd10) ? 5'(s1_q_ff - 5'd10) : s1_q_ff;
      s2_m_in   = (th_digit <= 5'd3) ? th_digit[1:0] : 2'd0;

      prod_100  = 21'(s2_r_ff) * 21'(Recip100);
      s3_h_in   = prod_100[20:17];

      h_times   = 10'(s3_h_ff) * 10'(Hundred);
      s4_r_in   = 7'(s3_r_ff - h_times);

      prod_10   = 15'(s4_r_ff) * 15'(Recip10);
      s5_t_in   = prod_10[14:11];

      t_times       = 7'(s5_t_ff) * 7'(Ten);
      s6_d_in.m_cnt = s5_m_ff;
      s6_d_in.hun   = s5_h_ff;
      s6_d_in.ten   = s5_t_ff;
      s6_d_in.one   = 4'(s5_r_ff - t_times);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_v_ff <= in_valid;
         if (s2_rdy) s2_v_ff <= s1_v_ff;
         if (s3_rdy) s3_v_ff <= s2_v_ff;
         if (s4_rdy) s4_v_ff <= s3_v_ff;
         if (s5_rdy) s5_v_ff <= s4_v_ff;
         if (s6_rdy) s6_v_ff <= s5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_val_ff <= s1_val_in;
         s1_q_ff   <= s1_q_in;
      end
      if (s2_rdy) begin
         s2_r_ff <= s2_r_in;
         s2_m_ff <= s2_m_in;
      end
      if (s3_rdy) begin
         s3_r_ff <= s2_r_ff;
         s3_m_ff <= s2_m_ff;
         s3_h_ff <= s3_h_in;
      end
      if (s4_rdy) begin
         s4_m_ff <= s3_m_ff;
         s4_h_ff <= s3_h_ff;
         s4_r_ff <= s4_r_in;
      end
      if (s5_rdy) begin
         s5_m_ff <= s4_m_ff;
         s5_h_ff <= s4_h_ff;
         s5_r_ff <= s4_r_ff;
         s5_t_ff <= s5_t_in;
      end
      if (s6_rdy) begin
         s6_d_ff <= s6_d_in;
      end
   end

   assign out_valid  = s6_v_ff;
   assign out_digits = s6_d_ff;

endmodule

### src/rne_pack.sv
// ----------------------------------------------------------------------------
// rne_pack
// Two-stage pipeline turning the digits into one packed symbol sequence,
// first symbol in the low bits, with its length.
// ----------------------------------------------------------------------------
module rne_pack (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  rne_pkg::digits_type       in_digits,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [rne_pkg::SeqW-1:0]  out_seq,
   output logic [rne_pkg::LenW-1:0]  out_len
);
   import rne_pkg::*;

   logic p1_v_ff, p2_v_ff;
   logic p1_rdy, p2_rdy;

   logic [SeqW-1:0] m_pat;
   logic [SeqW-1:0] mh_seq_ff, mh_seq_in;
   logic [LenW-1:0] mh_len_ff, mh_len_in;
   logic [PatW-1:0] t_pat_ff, t_pat_in;
   logic [PatW-1:0] u_pat_ff, u_pat_in;
   logic [2:0]      t_len_ff, t_len_in;
   logic [2:0]      u_len_ff, u_len_in;
   logic [PatW-1:0] h_pat;
   logic [2:0]      h_len;
   logic [LenW-1:0] mht_len;

   logic [SeqW-1:0] seq_ff, seq_in;
   logic [LenW-1:0] len_ff, len_in;

   assign p2_rdy   = !p2_v_ff || out_ready;
   assign p1_rdy   = !p1_v_ff || p2_rdy;
   assign in_ready = p1_rdy;

   always_comb begin
      case (in_digits.m_cnt)
         2'd1:    m_pat = SeqW'({SYM_M});
         2'd2:    m_pat = SeqW'({SYM_M, SYM_M});
         2'd3:    m_pat = SeqW'({SYM_M, SYM_M, SYM_M});
         default: m_pat = '0;
      endcase
      h_pat     = digit_syms(in_digits.hun, SYM_C, SYM_D, SYM_M);
      h_len     = digit_len(in_digits.hun);
      mh_seq_in = m_pat | (SeqW'(h_pat) << sym_shift(LenW'(in_digits.m_cnt)));
      mh_len_in = LenW'(in_digits.m_cnt) + LenW'(h_len);
      t_pat_in  = digit_syms(in_digits.ten, SYM_X, SYM_L, SYM_C);
      t_len_in  = digit_len(in_digits.ten);
      u_pat_in  = digit_syms(in_digits.one, SYM_I, SYM_V, SYM_X);
      u_len_in  = digit_len(in_digits.one);

      mht_len = mh_len_ff + LenW'(t_len_ff);
      seq_in  = mh_seq_ff
              | (SeqW'(t_pat_ff) << sym_shift(mh_len_ff))
              | (SeqW'(u_pat_ff) << sym_shift(mht_len));
      len_in  = mht_len + LenW'(u_len_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
      end else begin
         if (p1_rdy) p1_v_ff <= in_valid;
         if (p2_rdy) p2_v_ff <= p1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p1_rdy) begin
         mh_seq_ff <= mh_seq_in;
         mh_len_ff <= mh_len_in;
         t_pat_ff  <= t_pat_in;
         t_len_ff  <= t_len_in;
         u_pat_ff  <= u_pat_in;
         u_len_ff  <= u_len_in;
      end
      if (p2_rdy) begin
         seq_ff <= seq_in;
         len_ff <= len_in;
      end
   end

   assign out_valid = p2_v_ff;
   assign out_seq   = seq_ff;
   assign out_len   = len_ff;

endmodule

### src/rne_emit.sv
// ----------------------------------------------------------------------------
// rne_emit
// Letter emitter: shifts one symbol per transfer out of the held sequence
// into the result register; an empty sequence gives a single empty result.
// ----------------------------------------------------------------------------
module rne_emit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [rne_pkg::SeqW-1:0]     in_seq,
   input  logic [rne_pkg::LenW-1:0]     in_len,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rne_pkg::LetterW-1:0]  rsp_letter,
   output logic                         rsp_last,
   output logic                         rsp_empty_res
);
   import rne_pkg::*;

   logic               busy_ff, busy_in;
   logic [SeqW-1:0]    seq_ff, seq_in;
   logic [LenW-1:0]    rem_ff, rem_in;
   logic               out_v_ff, out_v_in;
   logic [LetterW-1:0] letter_ff, letter_in;
   logic               last_ff, last_in;
   logic               empty_ff, empty_in;
   logic               out_load, done, step, take;

   always_comb begin
      out_load = !out_v_ff || rsp_ready;
      done     = (rem_ff == LenW'(0)) || (rem_ff == LenW'(1));
      step     = busy_ff && out_load;
      in_ready = !busy_ff || (out_load && done);
      take     = in_valid && in_ready;

      busy_in = busy_ff;
      seq_in  = seq_ff;
      rem_in  = rem_ff;
      if (step) begin
         busy_in = !done;
         seq_in  = seq_ff >> SymW;
         rem_in  = rem_ff - LenW'(1);
      end
      if (take) begin
         busy_in = 1'b1;
         seq_in  = in_seq;
         rem_in  = in_len;
      end

      out_v_in  = step ? 1'b1 : (out_v_ff && !rsp_ready);
      letter_in = sym_ascii(sym_type'(seq_ff[SymW-1:0]));
      last_in   = done;
      empty_in  = (rem_ff == LenW'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff <= seq_in;
      rem_ff <= rem_in;
      if (step) begin
         letter_ff <= letter_in;
         last_ff   <= last_in;
         empty_ff  <= empty_in;
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_letter    = letter_ff;
   assign rsp_last      = last_ff;
   assign rsp_empty_res = empty_ff;

endmodule
